[src/msr_pkg.sv]
// Shared constants and types for the matrix shell rotation block.
`default_nettype none

package msr_pkg;

   localparam int MAX_ROWS  = 16;
   localparam int MAX_COLS  = 16;
   localparam int EDGE_PAIRS = 2;

   localparam int WORD_W    = 32;
   localparam int IDX_W     = 4;
   localparam int ROWCNT_W  = 5;
   localparam int COLCNT_W  = 5;
   localparam int SHELL_W   = 4;
   localparam int ROT_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int LEN_W     = $clog2(EDGE_PAIRS * (MAX_ROWS + MAX_COLS));
   localparam int GEO_W     = $clog2(EDGE_PAIRS * (MAX_ROWS + MAX_COLS) + 1) + 3;
   localparam int CRD_W     = GEO_W - 1;
   localparam int STEP_W    = $clog2(ROT_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COLUMN_COUNT = 2'd1,
      CSR_SHELL_NUMBER = 2'd2,
      CSR_ROTATION     = 2'd3
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_MAP   = 7'b0001000,
      ST_ADDR  = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

[src/msr_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module msr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/matrix_shell_rotate.sv]
// Matrix store with rotated-shell reads.
//
// Holds up to MAX_ROWS x MAX_COLS signed 32-bit words. A write item (mode 0)
// stores req_value at (req_row, req_column) on acceptance and gives no result.
// A read item (mode 1) returns the word seen at (req_row, req_column) when the
// selected shell is rotated by the rotation register; cells off the shell,
// and all cells when the shell is degenerate or outside the matrix, read back
// unchanged. A read of a cell on the shell passes from acceptance through the
// setup state, the bit-serial remainder unit that reduces the rotation modulo
// the ring length (one compare and subtract per rotation bit), the mapping
// states ST_MAP and ST_ADDR and the synchronous RAM read in ST_READ and ST_OUT
// to rsp_valid. Any other read skips the remainder and mapping. The input
// side stalls until the read result is loaded into the output register; a
// result waiting in that register does not block the next item. The user
// must write configuration registers only while no read is in flight; the
// block does not enforce this. Unwritten words read back as arbitrary data.
`default_nettype none

module matrix_shell_rotate (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [msr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [msr_pkg::CSR_DAT_W-1:0]       csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [msr_pkg::IDX_W-1:0]           req_row,
   input  wire logic [msr_pkg::IDX_W-1:0]           req_column,
   input  wire logic signed [msr_pkg::WORD_W-1:0]   req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [msr_pkg::WORD_W-1:0]        rsp_cell_value
);

   import msr_pkg::*;

   state_type state_ff, state_in;

   logic [ROWCNT_W-1:0]     row_count_ff;
   logic [COLCNT_W-1:0]     column_count_ff;
   logic [SHELL_W-1:0]      shell_number_ff;
   logic signed [ROT_W-1:0] rotation_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic signed [GEO_W-1:0] k_ff, k_in;
   logic signed [GEO_W-1:0] j_ff, j_in;
   logic [CRD_W-1:0]        rr_ff, rr_in;
   logic [CRD_W-1:0]        cc_ff, cc_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [ROT_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    zero_ff, zero_in;

   // shell geometry from the configuration registers
   logic signed [GEO_W-1:0] n_s, m_s, s_s, minr, minc, maxr, maxc, h_s, w_s, len_s;
   logic signed [GEO_W-1:0] r_s, c_s;
   logic                    shell_ok, on_shell;
   logic [LEN_W-1:0]        len_u;

   always_comb begin
      n_s   = (int'(row_count_ff) > MAX_ROWS) ? GEO_W'(MAX_ROWS) : GEO_W'(row_count_ff);
      m_s   = (int'(column_count_ff) > MAX_COLS) ? GEO_W'(MAX_COLS)
                                                 : GEO_W'(column_count_ff);
      s_s   = signed'(GEO_W'(shell_number_ff));
      minr  = s_s - GEO_W'(1);
      minc  = minr;
      maxr  = n_s - s_s;
      maxc  = m_s - s_s;
      h_s   = maxr - minr;
      w_s   = maxc - minc;
      len_s = GEO_W'(EDGE_PAIRS) * (h_s + w_s);
      len_u = LEN_W'(len_s);
      shell_ok = (s_s >= GEO_W'(1)) && (h_s >= GEO_W'(1)) && (w_s >= GEO_W'(1));
      r_s = signed'(GEO_W'(row_ff));
      c_s = signed'(GEO_W'(col_ff));
      on_shell = shell_ok && (r_s >= minr) && (r_s <= maxr) && (c_s >= minc) &&
                 (c_s <= maxc) &&
                 ((r_s == minr) || (r_s == maxr) || (c_s == minc) || (c_s == maxc));
   end

   // remainder unit and mapping arithmetic
   logic [LEN_W:0]          trial;
   logic [LEN_W-1:0]        rm;
   logic signed [GEO_W-1:0] rm_s, j_raw;
   logic [ROT_W-1:0]        rot_mag;
   logic                    rd_en;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [WORD_W-1:0]       rd_data;
   logic                    req_accept;

   assign rot_mag = rotation_ff[ROT_W-1] ? unsigned'(-rotation_ff) : unsigned'(rotation_ff);
   assign trial   = {rem_ff, quo_ff[ROT_W-1]};
   assign rm      = (rotation_ff[ROT_W-1] && (rem_ff != '0)) ? LEN_W'(len_u - rem_ff) : rem_ff;
   assign rm_s    = signed'(GEO_W'(rm));
   assign j_raw   = k_ff - rm_s;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && !req_mode &&
                       (int'(req_row) < MAX_ROWS) && (int'(req_column) < MAX_COLS);
   assign wr_addr    = ADDR_W'(int'(req_row) * MAX_COLS + int'(req_column));
   assign rd_en      = (state_ff == ST_READ);
   assign rd_addr    = ADDR_W'(int'(rr_ff) * MAX_COLS + int'(cc_ff));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      rr_in        = rr_ff;
      cc_in        = cc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_mode) begin
               row_in   = req_row;
               col_in   = req_column;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rem_in  = '0;
            quo_in  = rot_mag;
            step_in = STEP_W'(ROT_W - 1);
            if (c_s == minc) begin
               k_in = r_s - minr;
            end else if (r_s == maxr) begin
               k_in = h_s + (c_s - minc);
            end else if (c_s == maxc) begin
               k_in = h_s + w_s + (maxr - r_s);
            end else begin
               k_in = GEO_W'(EDGE_PAIRS) * h_s + w_s + (maxc - c_s);
            end
            if (on_shell) begin
               state_in = ST_DIV;
            end else begin
               rr_in    = CRD_W'(row_ff);
               cc_in    = CRD_W'(col_ff);
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, len_u}) begin
               rem_in = LEN_W'(trial - {1'b0, len_u});
            end else begin
               rem_in = LEN_W'(trial);
            end
            quo_in  = {quo_ff[ROT_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            j_in     = (j_raw < 0) ? (j_raw + len_s) : j_raw;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (j_ff <= h_s) begin
               rr_in = CRD_W'(minr + j_ff);
               cc_in = CRD_W'(minc);
            end else if (j_ff <= h_s + w_s) begin
               rr_in = CRD_W'(maxr);
               cc_in = CRD_W'(minc + (j_ff - h_s));
            end else if (j_ff <= GEO_W'(EDGE_PAIRS) * h_s + w_s) begin
               rr_in = CRD_W'(maxr - (j_ff - h_s - w_s));
               cc_in = CRD_W'(maxc);
            end else begin
               rr_in = CRD_W'(minr);
               cc_in = CRD_W'(maxc - (j_ff - GEO_W'(EDGE_PAIRS) * h_s - w_s));
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            zero_in  = !((int'(rr_ff) < MAX_ROWS) && (int'(cc_ff) < MAX_COLS));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = zero_ff ? '0 : rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= ROWCNT_W'(16);
         column_count_ff <= COLCNT_W'(16);
         shell_number_ff <= SHELL_W'(1);
         rotation_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_ROW_COUNT:    row_count_ff    <= csr_data[ROWCNT_W-1:0];
               CSR_COLUMN_COUNT: column_count_ff <= csr_data[COLCNT_W-1:0];
               CSR_SHELL_NUMBER: shell_number_ff <= csr_data[SHELL_W-1:0];
               CSR_ROTATION:     rotation_ff     <= signed'(csr_data[ROT_W-1:0]);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      rr_ff       <= rr_in;
      cc_ff       <= cc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      zero_ff     <= zero_in;
   end

   msr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (unsigned'(req_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = signed'(rsp_data_ff);

endmodule

`default_nettype wire
